// ===== rtl/pool_allocator_evict_oldest_core_assert.svh =====
// Assertion macros for the pool allocator core.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef POOL_ALLOCATOR_EVICT_OLDEST_CORE_ASSERT_SVH
`define POOL_ALLOCATOR_EVICT_OLDEST_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check an expression at every clock edge outside reset
`define PAE_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// Check that an antecedent implies a consequent in the next cycle
`define PAE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PAE_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define PAE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/pae_pkg.sv =====
// Shared types and constants for the pool allocator core.
// No dependencies; used by pae_front, pae_engine and the top level.
package pae_pkg;

   localparam int POOL_ENTRIES_DEF = 512;
   localparam int FRAME_MS         = 100;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   // One classified command as held in the queue
   typedef struct packed {
      op_type      op;
      logic [8:0]  slot;
      logic        slot_ok;
      logic [7:0]  life;
      logic [31:0] now;
   } item_type;

   // Queue head as seen by the engine
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   // Per-slot record stored in the entry RAM
   typedef struct packed {
      logic        active;
      logic [7:0]  life;
      logic [31:0] start;
   } meta_type;

endpackage

// ===== rtl/pae_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pae_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not reading
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pae_front.sv =====
// Front end: accepts request transfers, classifies them, and queues them.
// Depends on pae_pkg.
module pae_front #(
   parameter int POOL_ENTRIES = pae_pkg::POOL_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_mode,
   input  logic [8:0]        req_slot,
   input  logic [7:0]        req_lifetime_frames,
   input  logic [31:0]       req_now_ms,
   output pae_pkg::head_type head,
   input  logic              pop
);

   pae_pkg::item_type q0_ff, q0_in, q1_ff, q1_in, new_item;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push;

   // Classify the incoming item
   always_comb begin
      new_item.op      = pae_pkg::op_type'(req_mode);
      new_item.slot    = req_slot;
      new_item.slot_ok = ({23'd0, req_slot} < 32'(POOL_ENTRIES));
      new_item.life    = req_lifetime_frames;
      new_item.now     = req_now_ms;
   end

   assign req_stall  = (cnt_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = q0_ff;

   // Two-entry shift queue
   always_comb begin
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      cnt_in = cnt_ff;
      case ({push, pop})
         2'b10: begin
            if (cnt_ff == 2'd0) q0_in = new_item;
            else q1_in = new_item;
            cnt_in = cnt_ff + 2'd1;
         end
         2'b01: begin
            q0_in  = q1_ff;
            cnt_in = cnt_ff - 2'd1;
         end
         2'b11: begin
            if (cnt_ff == 2'd1) q0_in = new_item;
            else begin
               q0_in = q1_ff;
               q1_in = new_item;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

endmodule

// ===== rtl/pae_engine.sv =====
// Back end: executes queued commands on the linked lists held in RAM.
// Depends on pae_pkg and pae_ram.
module pae_engine #(
   parameter int POOL_ENTRIES = pae_pkg::POOL_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  pae_pkg::head_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [8:0]        rsp_given_slot,
   output logic              rsp_evicted,
   output logic [9:0]        rsp_expired_count,
   output logic [9:0]        rsp_active_count,
   output logic              rsp_bad_free
);

   localparam int IW = $clog2(POOL_ENTRIES);
   localparam int LW = $clog2(POOL_ENTRIES + 1);
   localparam int MW = $bits(pae_pkg::meta_type);
   localparam logic [LW-1:0] NIL  = LW'(POOL_ENTRIES);
   localparam logic [IW-1:0] LAST = IW'(POOL_ENTRIES - 1);

   typedef enum logic [12:0] {
      ST_SWEEP    = 13'b0000000000001,
      ST_IDLE     = 13'b0000000000010,
      ST_DISPATCH = 13'b0000000000100,
      ST_AL_POP   = 13'b0000000001000,
      ST_UNLINK   = 13'b0000000010000,
      ST_FR_CHECK = 13'b0000000100000,
      ST_REL      = 13'b0000001000000,
      ST_LINK_A   = 13'b0000010000000,
      ST_LINK_B   = 13'b0000100000000,
      ST_TK_ISSUE = 13'b0001000000000,
      ST_TK_AGE   = 13'b0010000000000,
      ST_TK_DEC   = 13'b0100000000000,
      ST_RESULT   = 13'b1000000000000
   } state_type;

   state_type         state_ff, state_in;
   pae_pkg::item_type cmd_ff, cmd_in;
   logic [LW-1:0]     cur_ff, cur_in, nx_ff, nx_in, fh_ff, fh_in;
   logic [LW-1:0]     newest_ff, newest_in, oldest_ff, oldest_in;
   logic [LW-1:0]     live_ff, live_in, exp_ff, exp_in, guard_ff, guard_in;
   logic [IW-1:0]     sweep_ff, sweep_in;
   logic              evict_ff, evict_in, bad_ff, bad_in, clr_ff, clr_in;
   logic [31:0]       age_ff, age_in;
   logic [14:0]       thr_ff, thr_in;
   logic              low_ff, low_in;
   logic [7:0]        life_m1;
   logic              expired;

   logic              rsp_valid_ff, rsp_valid_in, load;
   logic [8:0]        given_ff, given_in;
   logic              evicted_ff, evicted_in, badout_ff, badout_in;
   logic [9:0]        expcnt_ff, expcnt_in, actcnt_ff, actcnt_in;
   logic [LW+8:0]     given_wide;
   logic [LW+9:0]     exp_wide, live_wide;

   // RAM ports
   logic              nl_we, pl_we, mt_we, nl_re, pl_re, mt_re;
   logic [IW-1:0]     nl_wa, pl_wa, mt_wa, rd_addr;
   logic [LW-1:0]     nl_wd, pl_wd, nl_rd, pl_rd;
   pae_pkg::meta_type mt_wd, mt_rd;
   logic [MW-1:0]     mt_rd_raw;

   pae_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_next (
      .clock(clock), .wr_en(nl_we), .wr_addr(nl_wa), .wr_data(nl_wd),
      .rd_en(nl_re), .rd_addr(rd_addr), .rd_data(nl_rd)
   );
   pae_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_prev (
      .clock(clock), .wr_en(pl_we), .wr_addr(pl_wa), .wr_data(pl_wd),
      .rd_en(pl_re), .rd_addr(rd_addr), .rd_data(pl_rd)
   );
   pae_ram #(.WIDTH(MW), .DEPTH(POOL_ENTRIES)) u_meta (
      .clock(clock), .wr_en(mt_we), .wr_addr(mt_wa), .wr_data(mt_wd),
      .rd_en(mt_re), .rd_addr(rd_addr), .rd_data(mt_rd_raw)
   );
   assign mt_rd = pae_pkg::meta_type'(mt_rd_raw);

   // Expiry: floor(age/100) >= life-1  <=>  age >= (life-1)*100
   assign life_m1 = mt_rd.life - 8'd1;
   assign expired = low_ff || (!age_ff[31] && (age_ff >= {17'd0, thr_ff}));

   assign load = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      cur_in    = cur_ff;
      nx_in     = nx_ff;
      fh_in     = fh_ff;
      newest_in = newest_ff;
      oldest_in = oldest_ff;
      live_in   = live_ff;
      exp_in    = exp_ff;
      guard_in  = guard_ff;
      sweep_in  = sweep_ff;
      evict_in  = evict_ff;
      bad_in    = bad_ff;
      clr_in    = clr_ff;
      age_in    = age_ff;
      thr_in    = thr_ff;
      low_in    = low_ff;
      pop       = 1'b0;
      nl_we = 1'b0; pl_we = 1'b0; mt_we = 1'b0;
      nl_re = 1'b0; pl_re = 1'b0; mt_re = 1'b0;
      nl_wa = '0; pl_wa = '0; mt_wa = '0; rd_addr = '0;
      nl_wd = '0; pl_wd = '0; mt_wd = '0;
      unique case (state_ff)
         ST_SWEEP: begin
            nl_we = 1'b1; pl_we = 1'b1; mt_we = 1'b1;
            nl_wa = sweep_ff; pl_wa = sweep_ff; mt_wa = sweep_ff;
            nl_wd = LW'(sweep_ff) + LW'(1);
            pl_wd = NIL;
            fh_in = '0; newest_in = NIL; oldest_in = NIL; live_in = '0;
            if (sweep_ff == LAST) begin
               sweep_in = '0;
               state_in = clr_ff ? ST_RESULT : ST_IDLE;
            end else begin
               sweep_in = sweep_ff + IW'(1);
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               cmd_in   = head.item;
               evict_in = 1'b0;
               bad_in   = 1'b0;
               clr_in   = 1'b0;
               exp_in   = '0;
               guard_in = '0;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (cmd_ff.op)
               pae_pkg::OP_CLEAR: begin
                  clr_in   = 1'b1;
                  state_in = ST_SWEEP;
               end
               pae_pkg::OP_ALLOC: begin
                  if (fh_ff != NIL) begin
                     cur_in   = fh_ff;
                     nl_re    = 1'b1;
                     rd_addr  = fh_ff[IW-1:0];
                     state_in = ST_AL_POP;
                  end else begin
                     cur_in   = oldest_ff;
                     evict_in = 1'b1;
                     nl_re    = 1'b1;
                     pl_re    = 1'b1;
                     rd_addr  = oldest_ff[IW-1:0];
                     state_in = ST_UNLINK;
                  end
               end
               pae_pkg::OP_FREE: begin
                  if (!cmd_ff.slot_ok) begin
                     bad_in   = 1'b1;
                     state_in = ST_RESULT;
                  end else begin
                     cur_in   = LW'(cmd_ff.slot);
                     nl_re    = 1'b1;
                     pl_re    = 1'b1;
                     mt_re    = 1'b1;
                     rd_addr  = IW'(cmd_ff.slot);
                     state_in = ST_FR_CHECK;
                  end
               end
               default: begin
                  cur_in   = newest_ff;
                  state_in = ST_TK_ISSUE;
               end
            endcase
         end
         ST_AL_POP: begin
            fh_in    = nl_rd;
            live_in  = live_ff + LW'(1);
            state_in = ST_LINK_A;
         end
         ST_FR_CHECK: begin
            if (mt_rd.active) state_in = ST_UNLINK;
            else begin
               bad_in   = 1'b1;
               state_in = ST_RESULT;
            end
         end
         ST_UNLINK: begin
            // Bypass the slot: prev and next links are still on the read ports
            if (pl_rd != NIL) begin
               nl_we = 1'b1;
               nl_wa = pl_rd[IW-1:0];
               nl_wd = nl_rd;
            end else begin
               newest_in = nl_rd;
            end
            if (nl_rd != NIL) begin
               pl_we = 1'b1;
               pl_wa = nl_rd[IW-1:0];
               pl_wd = pl_rd;
            end else begin
               oldest_in = pl_rd;
            end
            state_in = (cmd_ff.op == pae_pkg::OP_ALLOC) ? ST_LINK_A : ST_REL;
         end
         ST_REL: begin
            // Push the slot on the free list
            nl_we = 1'b1; pl_we = 1'b1; mt_we = 1'b1;
            nl_wa = cur_ff[IW-1:0]; pl_wa = cur_ff[IW-1:0]; mt_wa = cur_ff[IW-1:0];
            nl_wd = fh_ff;
            pl_wd = NIL;
            fh_in = cur_ff;
            if (live_ff != '0) live_in = live_ff - LW'(1);
            if (cmd_ff.op == pae_pkg::OP_FREE) begin
               state_in = ST_RESULT;
            end else begin
               cur_in   = nx_ff;
               guard_in = guard_ff + LW'(1);
               state_in = ST_TK_ISSUE;
            end
         end
         ST_LINK_A: begin
            // Insert the slot as newest
            nl_we = 1'b1; pl_we = 1'b1; mt_we = 1'b1;
            nl_wa = cur_ff[IW-1:0]; pl_wa = cur_ff[IW-1:0]; mt_wa = cur_ff[IW-1:0];
            nl_wd = newest_ff;
            pl_wd = NIL;
            mt_wd.active = 1'b1;
            mt_wd.life   = cmd_ff.life;
            mt_wd.start  = cmd_ff.now;
            if (newest_ff == NIL) begin
               oldest_in = cur_ff;
               newest_in = cur_ff;
               state_in  = ST_RESULT;
            end else begin
               state_in  = ST_LINK_B;
            end
         end
         ST_LINK_B: begin
            pl_we     = 1'b1;
            pl_wa     = newest_ff[IW-1:0];
            pl_wd     = cur_ff;
            newest_in = cur_ff;
            state_in  = ST_RESULT;
         end
         ST_TK_ISSUE: begin
            if (cur_ff == NIL || guard_ff == NIL) begin
               state_in = ST_RESULT;
            end else begin
               nl_re    = 1'b1;
               pl_re    = 1'b1;
               mt_re    = 1'b1;
               rd_addr  = cur_ff[IW-1:0];
               state_in = ST_TK_AGE;
            end
         end
         ST_TK_AGE: begin
            nx_in    = nl_rd;
            age_in   = cmd_ff.now - mt_rd.start;
            thr_in   = 15'(life_m1) * 15'(pae_pkg::FRAME_MS);
            low_in   = (mt_rd.life <= 8'd1);
            state_in = ST_TK_DEC;
         end
         ST_TK_DEC: begin
            if (expired) begin
               exp_in   = exp_ff + LW'(1);
               state_in = ST_UNLINK;
            end else begin
               cur_in   = nx_ff;
               guard_in = guard_ff + LW'(1);
               state_in = ST_TK_ISSUE;
            end
         end
         ST_RESULT: begin
            if (load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result register
   assign given_wide = {9'd0, cur_ff};
   assign exp_wide   = {10'd0, exp_ff};
   assign live_wide  = {10'd0, live_ff};
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      given_in     = given_ff;
      evicted_in   = evicted_ff;
      expcnt_in    = expcnt_ff;
      actcnt_in    = actcnt_ff;
      badout_in    = badout_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         given_in     = (cmd_ff.op == pae_pkg::OP_ALLOC) ? given_wide[8:0] : 9'd0;
         evicted_in   = evict_ff;
         expcnt_in    = exp_wide[9:0];
         actcnt_in    = live_wide[9:0];
         badout_in    = bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         clr_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fh_ff        <= '0;
         newest_ff    <= NIL;
         oldest_ff    <= NIL;
         live_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         fh_ff        <= fh_in;
         newest_ff    <= newest_in;
         oldest_ff    <= oldest_in;
         live_ff      <= live_in;
      end
      cmd_ff     <= cmd_in;
      cur_ff     <= cur_in;
      nx_ff      <= nx_in;
      exp_ff     <= exp_in;
      guard_ff   <= guard_in;
      evict_ff   <= evict_in;
      bad_ff     <= bad_in;
      age_ff     <= age_in;
      thr_ff     <= thr_in;
      low_ff     <= low_in;
      given_ff   <= given_in;
      evicted_ff <= evicted_in;
      expcnt_ff  <= expcnt_in;
      actcnt_ff  <= actcnt_in;
      badout_ff  <= badout_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_given_slot    = given_ff;
   assign rsp_evicted       = evicted_ff;
   assign rsp_expired_count = expcnt_ff;
   assign rsp_active_count  = actcnt_ff;
   assign rsp_bad_free      = badout_ff;

endmodule

// ===== rtl/pool_allocator_evict_oldest_core.sv =====
// Pool allocator with a free list and oldest-entry eviction.
// Request channel (req_*): mode, slot, lifetime_frames, now_ms; one transfer per
// command. Result channel (rsp_*): one result transfer per command, in order.
// Commands: clear, allocate (evicts the oldest active entry when the pool is
// full), free a slot (bad_free flags an inactive or out-of-range slot), and tick
// (walks the active list newest first and frees expired entries).
// Requests land in a two-entry queue; the engine runs one command at a time on
// three RAMs (next links, prev links, slot records) with one read and one write
// port each. Reset starts a clearing pass that writes every RAM slot; requests
// still queue (two deep) but are not executed until it ends.
// The result sits in an output register; while rsp_stall is high it holds and
// the engine waits with its next result, while the queue keeps taking requests
// until its two entries are full.
module pool_allocator_evict_oldest_core #(
   parameter int POOL_ENTRIES = pae_pkg::POOL_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [8:0]  req_slot,
   input  logic [7:0]  req_lifetime_frames,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [8:0]  rsp_given_slot,
   output logic        rsp_evicted,
   output logic [9:0]  rsp_expired_count,
   output logic [9:0]  rsp_active_count,
   output logic        rsp_bad_free
);

`include "pool_allocator_evict_oldest_core_assert.svh"

   localparam logic [9:0] FULL_COUNT = 10'(POOL_ENTRIES);

   pae_pkg::head_type head;
   logic              pop;

   pae_front #(.POOL_ENTRIES(POOL_ENTRIES)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_slot(req_slot), .req_lifetime_frames(req_lifetime_frames),
      .req_now_ms(req_now_ms), .head(head), .pop(pop)
   );

   pae_engine #(.POOL_ENTRIES(POOL_ENTRIES)) u_engine (
      .clock(clock), .reset(reset), .head(head), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_given_slot(rsp_given_slot), .rsp_evicted(rsp_evicted),
      .rsp_expired_count(rsp_expired_count), .rsp_active_count(rsp_active_count),
      .rsp_bad_free(rsp_bad_free)
   );

   // Engine only dequeues a present item
   `PAE_ASSERT_ALWAYS(a_pop_has_head, clock, reset, !pop || head.valid)
   // Eviction only happens with a full pool
   `PAE_ASSERT_ALWAYS(a_evict_full, clock, reset,
      !(rsp_valid && rsp_evicted) || (rsp_active_count == FULL_COUNT))
   // A rejected free reports no given slot and no eviction
   `PAE_ASSERT_ALWAYS(a_bad_free_clean, clock, reset,
      !(rsp_valid && rsp_bad_free) || (rsp_given_slot == 9'd0 && !rsp_evicted))
   // A result is never produced in the cycle right after a dequeue
   `PAE_ASSERT_NEXT(a_pop_no_result, clock, reset, pop && !rsp_valid, !rsp_valid)

endmodule
